// ===== hdl/skbs_pkg.sv =====
// ----------------------------------------------------------------------------
// skbs_pkg: shared types and constants of the sorted key binary search unit
// Field widths, function codes, sequencer step codes and the microcode table.
// ----------------------------------------------------------------------------
package skbs_pkg;

    // Fixed field widths.
    localparam int KEY_W = 32;
    localparam int IDX_W = 10;
    localparam int POS_W = 10;
    localparam int CNT_W = 11;

    // Function codes of an input beat.
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    // Sequencer steps; the step counter holds one of these.
    typedef enum logic [2:0] {
        STEP_IDLE,
        STEP_PROBE,
        STEP_COMPARE,
        STEP_MISS,
        STEP_HIT
    } t_step;

    // Branch conditions a control word can test.
    typedef enum logic [1:0] {
        COND_SEARCH_BEAT,
        COND_EMPTY,
        COND_HIT,
        COND_OUT_FREE
    } t_cond;

    // Datapath operations.
    typedef enum logic [2:0] {
        OP_ACCEPT,
        OP_READ,
        OP_NARROW,
        OP_RES_MISS,
        OP_RES_HIT
    } t_op;

    // One control word of the program.
    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step on_true;
        t_step on_false;
    } t_uword;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic search_beat;
        logic empty;
        logic hit;
        logic out_free;
    } t_status;

    // Microcode program: one word per step.
    function automatic t_uword ucode_rom(input t_step step);
        t_uword w;
        case (step)
            STEP_IDLE:    w = '{OP_ACCEPT,   COND_SEARCH_BEAT, STEP_PROBE, STEP_IDLE};
            STEP_PROBE:   w = '{OP_READ,     COND_EMPTY,       STEP_MISS,  STEP_COMPARE};
            STEP_COMPARE: w = '{OP_NARROW,   COND_HIT,         STEP_HIT,   STEP_PROBE};
            STEP_MISS:    w = '{OP_RES_MISS, COND_OUT_FREE,    STEP_IDLE,  STEP_MISS};
            STEP_HIT:     w = '{OP_RES_HIT,  COND_OUT_FREE,    STEP_IDLE,  STEP_HIT};
            default:      w = '{OP_ACCEPT,   COND_SEARCH_BEAT, STEP_IDLE,  STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/skbs_if.sv =====
// ----------------------------------------------------------------------------
// skbs_if: channel interfaces of the sorted key binary search unit
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------

// Request channel: load or search beats.
interface skbs_req_if;
    logic                               valid;
    logic                               ready;
    logic                               func;
    logic [skbs_pkg::IDX_W-1:0]         entry_index;
    logic signed [skbs_pkg::KEY_W-1:0]  key_value;

    modport source (output valid, func, entry_index, key_value, input ready);
    modport sink   (input valid, func, entry_index, key_value, output ready);
endinterface

// Response channel: one beat per search.
interface skbs_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [skbs_pkg::POS_W-1:0] position;

    modport source (output valid, found, position, input ready);
    modport sink   (input valid, found, position, output ready);
endinterface

// Configuration channel: writes the entry count.
interface skbs_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [skbs_pkg::CNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/skbs_seq.sv =====
// ----------------------------------------------------------------------------
// skbs_seq: microcode sequencer
// Holds the step counter, reads the control word and picks the next step
// from the branch condition selected by that word.
// ----------------------------------------------------------------------------
module skbs_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  skbs_pkg::t_status i_status,
    output skbs_pkg::t_uword  o_uword
);
    import skbs_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword w_uword;
    logic   w_cond;

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // Control word fetch and branch.
    always_comb begin
        w_uword = ucode_rom(r_step);
        case (w_uword.cond)
            COND_SEARCH_BEAT: w_cond = i_status.search_beat;
            COND_EMPTY:       w_cond = i_status.empty;
            COND_HIT:         w_cond = i_status.hit;
            COND_OUT_FREE:    w_cond = i_status.out_free;
            default:          w_cond = 1'b0;
        endcase
        n_step  = w_cond ? w_uword.on_true : w_uword.on_false;
        o_uword = w_uword;
    end

endmodule

// ===== hdl/sorted_key_binary_search_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_key_binary_search_unit: key table with microcoded binary search
// A search makes p probes, p at most clog2(min(entry_count, depth) + 1):
// each probe is one registered read of the key memory and a compare.
// Reset clears the sequencer, entry count and result valid; keys are undefined.
// ----------------------------------------------------------------------------
module sorted_key_binary_search_unit #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    skbs_req_if.sink   i_req,
    skbs_rsp_if.source o_rsp,
    skbs_cfg_if.sink   i_cfg
);
    import skbs_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int BW = $clog2(TABLE_DEPTH + 1);

    t_uword  w_uword;
    t_status w_status;

    logic [CNT_W-1:0]        r_entry_count;
    logic [KEY_W-1:0]        mem [TABLE_DEPTH];
    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] r_rd;
    logic [AW-1:0]           r_mid;
    logic [BW-1:0]           r_low;
    logic [BW-1:0]           r_hi;
    logic                    r_out_valid;
    logic                    r_found;
    logic [POS_W-1:0]        r_pos;

    logic                    w_req_beat;
    logic                    w_load_wr;
    logic [BW-1:0]           w_count;
    logic [BW:0]             w_sum;
    logic [AW-1:0]           w_mid;
    logic                    w_out_free;
    logic                    w_res;

    skbs_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_uword  (w_uword)
    );

    // Handshakes and status.
    always_comb begin
        i_req.ready  = (w_uword.op == OP_ACCEPT);
        i_cfg.ready  = 1'b1;
        w_req_beat   = i_req.valid && i_req.ready;
        w_load_wr    = w_req_beat && (i_req.func == FUNC_LOAD) &&
                       (32'(i_req.entry_index) < TABLE_DEPTH);
        w_count      = (32'(r_entry_count) > TABLE_DEPTH) ? BW'(TABLE_DEPTH)
                                                          : BW'(r_entry_count);
        // Midpoint of the half-open window [low, hi), rounded down.
        w_sum        = (BW+1)'(r_low) + (BW+1)'(r_hi) - (BW+1)'(1);
        w_mid        = w_sum[AW:1];
        w_out_free   = !r_out_valid || o_rsp.ready;
        w_res        = (w_uword.op == OP_RES_MISS) || (w_uword.op == OP_RES_HIT);
        w_status.search_beat = w_req_beat && (i_req.func == FUNC_SEARCH);
        w_status.empty       = (r_low >= r_hi);
        w_status.hit         = (r_rd == r_key);
        w_status.out_free    = w_out_free;
    end

    // Entry count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_entry_count <= i_cfg.data;
        end
    end

    // Key memory write port.
    always_ff @(posedge i_clk) begin
        if (w_load_wr) begin
            mem[AW'(i_req.entry_index)] <= i_req.key_value;
        end
    end

    // Key memory read port with registered data.
    always_ff @(posedge i_clk) begin
        if ((w_uword.op == OP_READ) && !w_status.empty) begin
            r_rd <= $signed(mem[w_mid]);
        end
    end

    // Search window and probe index.
    always_ff @(posedge i_clk) begin
        if (w_status.search_beat) begin
            r_key <= i_req.key_value;
            r_low <= '0;
            r_hi  <= w_count;
        end
        if ((w_uword.op == OP_READ) && !w_status.empty) begin
            r_mid <= w_mid;
        end
        if ((w_uword.op == OP_NARROW) && !w_status.hit) begin
            if (r_rd > r_key) begin
                r_hi <= BW'(r_mid);
            end else begin
                r_low <= BW'(r_mid) + BW'(1);
            end
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (w_res && w_out_free) begin
            r_found <= (w_uword.op == OP_RES_HIT);
            r_pos   <= (w_uword.op == OP_RES_HIT) ? POS_W'(r_mid) : '0;
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.found    = r_found;
    assign o_rsp.position = r_pos;

`ifndef SYNTHESIS
    // The search window never inverts.
    a_window_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_uword.op == OP_READ) |-> (r_low <= r_hi))
        else $error("search window inverted");

    // The upper bound stays within the table.
    a_window_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_uword.op == OP_READ) |-> (32'(r_hi) <= TABLE_DEPTH))
        else $error("search window past table depth");

    // A search beat starts a probe in the next cycle.
    a_search_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.search_beat |=> (w_uword.op == OP_READ))
        else $error("search beat did not start a probe");

    // A hit step that finds the output free presents a found result.
    a_hit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_uword.op == OP_RES_HIT) && w_out_free) |=> (r_out_valid && r_found))
        else $error("hit result not presented");

    // A miss result carries position zero.
    a_miss_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_found) |-> (r_pos == '0))
        else $error("miss result with nonzero position");
`endif

endmodule
